// ===== rtl/cvcd_pkg.sv =====
package cvcd_pkg;

  // Number of debounced channels and the slow stage divide ratio.
  localparam int CHANNELS    = 8;
  localparam int SLOW_DIVIDE = 4;

  // Width of the tick phase counter.
  localparam int PHASE_W = (SLOW_DIVIDE > 1) ? $clog2(SLOW_DIVIDE) : 1;

  // Fixed width of the channel fields on the ports.
  localparam int FIELD_W = 8;

  // Bits kept when the port test error flag is raised.
  localparam logic [FIELD_W-1:0] PORT_TEST_KEEP = 8'hF0;

  // One bit per channel.
  typedef logic [CHANNELS-1:0] chan_t;

  // Tick phase counter value.
  typedef logic [PHASE_W-1:0] phase_t;

endpackage

// ===== rtl/cascaded_vertical_counter_debouncer.sv =====
// Two-stage vertical counter debouncer for a bank of parallel channels.
// Input channel: in_valid / in_stall carry one tick, a raw sample of every
// channel plus the port test error flag. Output channel: out_valid /
// out_stall carry one result per tick: the held selection, the fast and
// slow debounced levels and a flag marking ticks on which the slow stage
// and the selection stepped.
// The fast stage steps on every tick; the slow stage steps on every
// SLOW_DIVIDE-th tick on the fast stage's new levels. The selection mask
// register (cfg_write_en / cfg_write_data) picks fast or slow per channel.
// A tick is accepted into the input register, and its result is presented
// when it passes into the result register. Throughput: one tick per cycle
// while the receiver does not stall, set by the single pass of bitwise logic
// between the two registers.
// Reset (rst, synchronous) clears both stages, the phase counter, the held
// selection, the mask and both valid flags. When the receiver stalls, the
// result is held and one further tick waits in the input register; in_stall
// rises only when both registers are full.
module cascaded_vertical_counter_debouncer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] raw_sample,
  input  logic       port_test_error,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] selected_inputs,
  output logic [7:0] fast_debounced,
  output logic [7:0] slow_debounced,
  output logic       slow_updated,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data
);

  logic                   hold_valid;
  cvcd_pkg::chan_t        hold_sample;
  logic                   hold_err;
  logic                   move;
  logic                   slow_step;
  cvcd_pkg::phase_t       phase;
  cvcd_pkg::chan_t        path_select_mask;
  cvcd_pkg::chan_t        held_selection;
  cvcd_pkg::chan_t        sel_raw;
  cvcd_pkg::chan_t        sel_next;
  cvcd_pkg::chan_t        fast_level;
  cvcd_pkg::chan_t        fast_level_next;
  cvcd_pkg::chan_t        slow_level;
  cvcd_pkg::chan_t        slow_level_next;

  // A tick moves on when the result register is empty or being drained.
  assign move     = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !move;

  // The slow stage steps on the tick that wraps the phase counter.
  assign slow_step = move && (phase == cvcd_pkg::phase_t'(cvcd_pkg::SLOW_DIVIDE - 1));

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_sample <= cvcd_pkg::chan_t'(raw_sample);
      hold_err    <= port_test_error;
    end
  end

  // Selection mask register.
  always_ff @(posedge clk) begin
    if (rst) begin
      path_select_mask <= '0;
    end else if (cfg_write_en) begin
      path_select_mask <= cvcd_pkg::chan_t'(cfg_write_data);
    end
  end

  // Tick phase counter, modulo SLOW_DIVIDE.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (move) begin
      if (slow_step) begin
        phase <= '0;
      end else begin
        phase <= phase + cvcd_pkg::phase_t'(1);
      end
    end
  end

  // Fast stage steps on every tick.
  cvcd_vc_stage u_fast (
    .clk        (clk),
    .rst        (rst),
    .step       (move),
    .sample     (hold_sample),
    .level      (fast_level),
    .level_next (fast_level_next)
  );

  // Slow stage follows the fast stage's updated levels.
  cvcd_vc_stage u_slow (
    .clk        (clk),
    .rst        (rst),
    .step       (slow_step),
    .sample     (fast_level_next),
    .level      (slow_level),
    .level_next (slow_level_next)
  );

  // Per-channel choice of fast or slow level, with the port test clamp.
  always_comb begin
    sel_raw  = (path_select_mask & fast_level_next) | (~path_select_mask & slow_level_next);
    sel_next = hold_err ? (sel_raw & cvcd_pkg::chan_t'(cvcd_pkg::PORT_TEST_KEEP)) : sel_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_selection <= '0;
    end else if (slow_step) begin
      held_selection <= sel_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      selected_inputs <= cvcd_pkg::FIELD_W'(slow_step ? sel_next : held_selection);
      fast_debounced  <= cvcd_pkg::FIELD_W'(fast_level_next);
      slow_debounced  <= cvcd_pkg::FIELD_W'(slow_level_next);
      slow_updated    <= slow_step;
    end
  end

`ifndef SYNTHESIS
  // The phase counter only advances when a transaction moves on.
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !move |=> $stable(phase))
    else $error("phase changed without a transaction");

  // The slow levels change only on a slow step.
  a_slow_hold: assert property (@(posedge clk) disable iff (rst)
    !slow_step |=> $stable(slow_level))
    else $error("slow stage changed outside a slow step");

  // The held selection changes only on a slow step.
  a_sel_hold: assert property (@(posedge clk) disable iff (rst)
    !slow_step |=> $stable(held_selection))
    else $error("selection changed outside a slow step");

  // A presented result carries the fast stage's current levels.
  a_fast_match: assert property (@(posedge clk) disable iff (rst)
    move |=> (fast_debounced == cvcd_pkg::FIELD_W'(fast_level)))
    else $error("result does not match fast stage levels");

  // A slow-updated result carries the selection just stored.
  a_sel_match: assert property (@(posedge clk) disable iff (rst)
    slow_step |=> (selected_inputs == cvcd_pkg::FIELD_W'(held_selection)))
    else $error("result does not match stored selection");
`endif

endmodule

// ===== rtl/cvcd_vc_stage.sv =====
module cvcd_vc_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  cvcd_pkg::chan_t sample,
  output cvcd_pkg::chan_t level,
  output cvcd_pkg::chan_t level_next
);

  cvcd_pkg::chan_t cnt_lo;
  cvcd_pkg::chan_t cnt_hi;
  cvcd_pkg::chan_t diff;
  cvcd_pkg::chan_t cnt_lo_next;
  cvcd_pkg::chan_t cnt_hi_next;
  cvcd_pkg::chan_t busy;

  // Two-bit vertical counter per channel: it counts only while the sample
  // differs from the level, and the level follows the sample when it wraps.
  always_comb begin
    diff        = sample ^ level;
    cnt_lo_next = (cnt_lo ^ cnt_hi) & diff;
    cnt_hi_next = ~cnt_hi & diff;
    busy        = cnt_lo_next | cnt_hi_next;
    level_next  = step ? ((busy & level) | (~busy & sample)) : level;
  end

  // Counter and level registers advance only on a step.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_lo <= '0;
      cnt_hi <= '0;
      level  <= '0;
    end else if (step) begin
      cnt_lo <= cnt_lo_next;
      cnt_hi <= cnt_hi_next;
      level  <= level_next;
    end
  end

endmodule

// ===== tb/cascaded_vertical_counter_debouncer_tb.sv =====
module cascaded_vertical_counter_debouncer_tb;
  import cvcd_pkg::*;

  localparam int MASK_PHASES  = 5;
  localparam int PHASE_TICKS  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // One input tick and one result transaction as they appear on the ports.
  typedef struct packed {
    logic [FIELD_W-1:0] raw;
    logic               err;
  } tick_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sel;
    logic [FIELD_W-1:0] fast;
    logic [FIELD_W-1:0] slow;
    logic               upd;
  } result_t;

  // Two-bit vertical counter per channel plus the debounced level.
  typedef struct packed {
    chan_t cnt_lo;
    chan_t cnt_hi;
    chan_t level;
  } stage_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] raw_sample = '0;
  logic               port_test_error = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] selected_inputs;
  logic [FIELD_W-1:0] fast_debounced;
  logic [FIELD_W-1:0] slow_debounced;
  logic               slow_updated;
  logic               cfg_write_en = 1'b0;
  logic [FIELD_W-1:0] cfg_write_data = '0;

  // Debouncer state as the block should hold it.
  stage_t fast_stage;
  stage_t slow_stage;
  int     tick_phase;
  chan_t  held_selection;
  chan_t  path_mask;

  tick_t   pending_ticks[$];
  result_t expected_results[$];
  tick_t   next_tick;

  int send_gap;
  int send_quiet;
  int stall_left;
  int stall_quiet;
  int cycle_count;
  int ticks_accepted;
  int slow_steps;
  int results_checked;
  int mismatches;

  cascaded_vertical_counter_debouncer uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_sample      (raw_sample),
    .port_test_error (port_test_error),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .selected_inputs (selected_inputs),
    .fast_debounced  (fast_debounced),
    .slow_debounced  (slow_debounced),
    .slow_updated    (slow_updated),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One step of a vertical counter stage: a level changes only after four
  // disagreeing samples in a row, and any agreeing sample clears the count.
  function automatic stage_t debounce_step(stage_t s, chan_t sample);
    chan_t  diff;
    chan_t  lo;
    chan_t  hi;
    chan_t  busy;
    stage_t n;
    diff = sample ^ s.level;
    lo = (s.cnt_lo ^ s.cnt_hi) & diff;
    hi = ~s.cnt_hi & diff;
    busy = lo | hi;
    n.cnt_lo = lo;
    n.cnt_hi = hi;
    n.level = (busy & s.level) | (~busy & sample);
    return n;
  endfunction

  // Advances the expected state by one accepted tick and queues its result.
  function automatic void debounce_tick(logic [FIELD_W-1:0] raw, logic err);
    result_t r;
    chan_t   sel;
    logic    slow_tick;
    fast_stage = debounce_step(fast_stage, raw[CHANNELS-1:0]);
    tick_phase = tick_phase + 1;
    if (tick_phase >= SLOW_DIVIDE) tick_phase = 0;
    slow_tick = (tick_phase == 0);
    if (slow_tick) begin
      // The slow stage sees the fast levels of this very tick.
      slow_stage = debounce_step(slow_stage, fast_stage.level);
      sel = (path_mask & fast_stage.level) | (~path_mask & slow_stage.level);
      if (err) sel = sel & PORT_TEST_KEEP[CHANNELS-1:0];
      held_selection = sel;
      slow_steps++;
    end
    r.sel  = FIELD_W'(held_selection);
    r.fast = FIELD_W'(fast_stage.level);
    r.slow = FIELD_W'(slow_stage.level);
    r.upd  = slow_tick;
    expected_results.push_back(r);
    ticks_accepted++;
  endfunction

  // Idle lengths: mostly none or short, now and then long, and occasional
  // quiet stretches with no idling at all.
  function automatic int draw_idle(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    case ($urandom_range(0, 19))
      0: return $urandom_range(8, 30);
      1, 2, 3, 4, 5, 6: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  function automatic void push_tick(logic [FIELD_W-1:0] raw, logic err);
    tick_t t;
    t.raw = raw;
    t.err = err;
    pending_ticks.push_back(t);
  endfunction

  function automatic void compare_field(string field, logic [FIELD_W-1:0] exp_val,
                                        logic [FIELD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %h, actual %h", field, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Driver: presents queued ticks, holds them while stalled, and updates the
  // expected state on every accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_quiet = 0;
      fast_stage = '0;
      slow_stage = '0;
      tick_phase = 0;
      held_selection = '0;
      path_mask = '0;
    end else begin
      if (cfg_write_en) path_mask = cfg_write_data[CHANNELS-1:0];
      if (in_valid && !in_stall) debounce_tick(raw_sample, port_test_error);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || pending_ticks.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          next_tick = pending_ticks.pop_front();
          in_valid <= 1'b1;
          raw_sample <= next_tick.raw;
          port_test_error <= next_tick.err;
          send_gap = draw_idle(send_quiet);
        end
      end
    end
  end

  // Monitor: stalls the result channel at random and checks each accepted
  // result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      stall_quiet = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("Unexpected result: selected_inputs %h, fast_debounced %h",
                 selected_inputs, fast_debounced);
          mismatches++;
        end else begin
          compare_field("selected_inputs", expected_results[0].sel, selected_inputs);
          compare_field("fast_debounced", expected_results[0].fast, fast_debounced);
          compare_field("slow_debounced", expected_results[0].slow, slow_debounced);
          compare_field("slow_updated", FIELD_W'(expected_results[0].upd),
                        FIELD_W'(slow_updated));
          void'(expected_results.pop_front());
          results_checked++;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = draw_idle(stall_quiet);
      end
    end
  end

  // Watchdog on the overall run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped by watchdog after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: one mask setting per phase, written only while the block is idle.
  initial begin
    logic [FIELD_W-1:0] masks [MASK_PHASES];
    logic [FIELD_W-1:0] level;
    logic [FIELD_W-1:0] sample;
    int made;
    int kind;
    int len;
    masks[0] = 8'h00;
    masks[1] = 8'hFF;
    masks[2] = 8'hA5;
    masks[3] = FIELD_W'($urandom_range(0, 255));
    masks[4] = 8'h3C;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < MASK_PHASES; p++) begin
      @(posedge clk);
      cfg_write_en <= 1'b1;
      cfg_write_data <= masks[p];
      @(posedge clk);
      cfg_write_en <= 1'b0;

      if (p == 0) begin
        // Directed ticks: a clean rise, a rise seen with the port test error,
        // a single bounce that must restart the count, a clean fall,
        // alternating patterns that never settle, and the low nibble under error.
        repeat (4) push_tick(8'hFF, 1'b0);
        repeat (4) push_tick(8'hFF, 1'b1);
        push_tick(8'h00, 1'b0);
        repeat (3) push_tick(8'hFF, 1'b0);
        repeat (4) push_tick(8'h00, 1'b0);
        repeat (2) begin
          push_tick(8'hAA, 1'b1);
          push_tick(8'h55, 1'b0);
        end
        repeat (4) push_tick(8'h0F, 1'b1);
      end

      // Random part: mostly steady runs with the odd one-channel glitch, some
      // long enough to move the slow stage, and a little pure noise.
      made = 0;
      while (made < PHASE_TICKS) begin
        kind = $urandom_range(0, 9);
        level = FIELD_W'($urandom_range(0, 255));
        len = (kind < 3) ? $urandom_range(12, 40) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          sample = level;
          if (kind == 9) sample = FIELD_W'($urandom_range(0, 255));
          else if ($urandom_range(0, 9) == 0)
            sample = sample ^ (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
          push_tick(sample, $urandom_range(0, 3) == 0);
          made++;
        end
      end

      // Let every queued tick go through and every result come back.
      do @(negedge clk);
      while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    $display("Checked %0d results from %0d ticks under %0d mask settings (%0d slow steps).",
             results_checked, ticks_accepted, MASK_PHASES, slow_steps);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cvcd_pkg.sv
rtl/cvcd_vc_stage.sv
rtl/cascaded_vertical_counter_debouncer.sv
tb/cascaded_vertical_counter_debouncer_tb.sv
